@@ rtl/core/fifo_cache_with_byte_budget_top_defines.svh @@
// ----------------------------------------------------------------------------
// FIFO cache assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef FIFO_CACHE_WITH_BYTE_BUDGET_TOP_DEFINES_SVH
`define FIFO_CACHE_WITH_BYTE_BUDGET_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FCB_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define FCB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define FCB_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define FCB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/fcb_pkg.sv @@
// ----------------------------------------------------------------------------
// FIFO cache package
// Shared codes and control structs.
// ----------------------------------------------------------------------------
`default_nettype none
package fcb_pkg;
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_LIVE   = 2'd2;
    localparam logic [1:0] ST_MISS   = 2'd3;

    localparam logic [1:0] REG_ENTRY_CAP = 2'd0;
    localparam logic [1:0] REG_BYTE_CAP  = 2'd1;
    localparam logic [1:0] REG_STATS     = 2'd2;

    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic hit_inc;
        logic miss_inc;
    } t_stat_upd;

    typedef struct packed {
        logic data_we;
        logic live_we;
        logic live_val;
    } t_mem_cmd;
endpackage
`default_nettype wire

@@ rtl/core/fcb_regs.sv @@
// ----------------------------------------------------------------------------
// FIFO cache register bank
// Configuration registers and saturating hit/miss counters.
// ----------------------------------------------------------------------------
`default_nettype none
module fcb_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [63:0]       pwdata,
    output logic      [63:0]       prdata,
    input  wire fcb_pkg::t_stat_upd i_upd,
    output logic      [10:0]       o_entry_cap,
    output logic      [47:0]       o_byte_cap,
    output logic      [47:0]       o_hits,
    output logic      [47:0]       o_misses
);
    import fcb_pkg::*;

    logic [10:0] r_ecap;
    logic [47:0] r_bcap;
    logic        r_stats;
    logic [47:0] r_hits;
    logic [47:0] r_misses;
    logic        wr;

    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecap   <= 11'd1024;
            r_bcap   <= 48'd268435456;
            r_stats  <= 1'b0;
            r_hits   <= '0;
            r_misses <= '0;
        end else begin
            if (wr && paddr[4:3] == REG_ENTRY_CAP && pwdata[10:0] > r_ecap) begin
                r_ecap <= pwdata[10:0];
            end
            if (wr && paddr[4:3] == REG_BYTE_CAP && pwdata[47:0] > r_bcap) begin
                r_bcap <= pwdata[47:0];
            end
            if (wr && paddr[4:3] == REG_STATS) begin
                r_stats  <= pwdata[0];
                r_hits   <= '0;
                r_misses <= '0;
            end else begin
                if (i_upd.hit_inc && r_stats && r_hits != MAX48) begin
                    r_hits <= r_hits + 48'd1;
                end
                if (i_upd.miss_inc && r_stats && r_misses != MAX48) begin
                    r_misses <= r_misses + 48'd1;
                end
            end
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_ENTRY_CAP: prdata = {53'd0, r_ecap};
            REG_BYTE_CAP:  prdata = {16'd0, r_bcap};
            REG_STATS:     prdata = {63'd0, r_stats};
            default:       prdata = '0;
        endcase
    end

    assign o_entry_cap = r_ecap;
    assign o_byte_cap  = r_bcap;
    assign o_hits      = r_hits;
    assign o_misses    = r_misses;
endmodule
`default_nettype wire

@@ rtl/core/fcb_store.sv @@
// ----------------------------------------------------------------------------
// FIFO cache slot store
// Key, size, handle and live memories with one write and one read port.
// ----------------------------------------------------------------------------
`default_nettype none
module fcb_store #(
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [63:0]      o_rd_fk,
    output logic      [63:0]      o_rd_lk,
    output logic      [31:0]      o_rd_sz,
    output logic      [31:0]      o_rd_pay,
    output logic                  o_rd_live,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire fcb_pkg::t_mem_cmd i_cmd,
    input  wire logic [63:0]      i_wr_fk,
    input  wire logic [63:0]      i_wr_lk,
    input  wire logic [31:0]      i_wr_sz,
    input  wire logic [31:0]      i_wr_pay
);
    import fcb_pkg::*;

    logic [63:0] mem_fk   [DEPTH];
    logic [63:0] mem_lk   [DEPTH];
    logic [31:0] mem_sz   [DEPTH];
    logic [31:0] mem_pay  [DEPTH];
    logic        mem_live [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.data_we) begin
            mem_fk[i_wr_addr]  <= i_wr_fk;
            mem_lk[i_wr_addr]  <= i_wr_lk;
            mem_sz[i_wr_addr]  <= i_wr_sz;
            mem_pay[i_wr_addr] <= i_wr_pay;
        end
        o_rd_fk  <= mem_fk[i_rd_addr];
        o_rd_lk  <= mem_lk[i_rd_addr];
        o_rd_sz  <= mem_sz[i_rd_addr];
        o_rd_pay <= mem_pay[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.live_we) begin
            mem_live[i_wr_addr] <= i_cmd.live_val;
        end
        o_rd_live <= mem_live[i_rd_addr];
    end
endmodule
`default_nettype wire

@@ rtl/core/fcb_seq.sv @@
// ----------------------------------------------------------------------------
// FIFO cache sequencer
// Runs eviction, key scan and update steps over the slot store.
// ----------------------------------------------------------------------------
`default_nettype none
module fcb_seq #(
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH),
    localparam int UW    = $clog2(DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_op,
    input  wire logic [63:0]       i_fk,
    input  wire logic [63:0]       i_lk,
    input  wire logic [31:0]       i_vsize,
    input  wire logic [31:0]       i_vhandle,
    input  wire logic [10:0]       i_entry_cap,
    input  wire logic [47:0]       i_byte_cap,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [1:0]        o_status,
    output logic      [31:0]       o_fh,
    output logic      [31:0]       o_fs,
    output logic      [UW-1:0]     o_evicted,
    output logic      [UW-1:0]     o_used,
    output logic      [47:0]       o_bytes,
    output fcb_pkg::t_stat_upd     o_upd,
    output logic      [AW-1:0]     o_rd_addr,
    input  wire logic [63:0]       i_rd_fk,
    input  wire logic [63:0]       i_rd_lk,
    input  wire logic [31:0]       i_rd_sz,
    input  wire logic [31:0]       i_rd_pay,
    input  wire logic              i_rd_live,
    output logic      [AW-1:0]     o_wr_addr,
    output fcb_pkg::t_mem_cmd      o_cmd,
    output logic      [63:0]       o_wr_fk,
    output logic      [63:0]       o_wr_lk,
    output logic      [31:0]       o_wr_sz,
    output logic      [31:0]       o_wr_pay
);
    import fcb_pkg::*;

    localparam int LW = (UW > 11) ? UW : 11;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_EVCHK, S_EVRD, S_EVDAT,
        S_SCAN, S_SCEND, S_EVCLR, S_FIN, S_OUT
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_clr;
    logic [1:0]    r_op;
    logic [63:0]   r_fk, r_lk, r_tfk, r_tlk;
    logic [31:0]   r_sz, r_hd;
    logic          r_evict_mode;
    logic [AW:0]   r_scan;
    logic          r_chk_v;
    logic [AW-1:0] r_chk_a;
    logic          r_hit;
    logic [AW-1:0] r_hit_a;
    logic [31:0]   r_hit_pay, r_hit_sz;
    logic [AW-1:0] r_oldest;
    logic [UW-1:0] r_used, r_ev;
    logic [47:0]   r_bytes;
    logic [1:0]    r_status;
    logic [31:0]   r_fh, r_fs;

    logic [LW-1:0] cap_ext, lim, used_ext;
    logic          need_evict;
    logic          hit_now;
    logic [AW:0]   tail_sum;
    logic [AW-1:0] tail;
    logic [48:0]   add_sum;

    assign cap_ext  = LW'(i_entry_cap);
    assign lim      = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
    assign used_ext = LW'(r_used);
    assign need_evict = (r_used != '0) && ((used_ext >= lim) || (r_bytes >= i_byte_cap));
    assign hit_now  = r_chk_v && i_rd_live && (i_rd_fk == r_tfk) && (i_rd_lk == r_tlk);
    assign tail_sum = {1'b0, r_oldest} + (AW + 1)'(r_used);
    assign tail     = (tail_sum >= (AW + 1)'(DEPTH)) ?
                      AW'(tail_sum - (AW + 1)'(DEPTH)) : tail_sum[AW-1:0];
    assign add_sum  = {1'b0, r_bytes} + 49'(r_sz);

    always_comb begin
        o_rd_addr = (r_state == S_SCAN) ? r_scan[AW-1:0] : r_oldest;
        o_wr_addr = r_oldest;
        o_cmd     = '0;
        o_upd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_wr_addr   = r_clr;
                o_cmd.live_we = 1'b1;
            end
            S_SCEND: begin
                o_wr_addr     = r_hit_a;
                o_cmd.live_we = r_evict_mode && r_hit;
            end
            S_EVCLR: begin
                o_cmd.live_we = 1'b1;
            end
            S_FIN: begin
                case (r_op)
                    OP_INSERT: begin
                        o_wr_addr      = tail;
                        o_cmd.data_we  = !r_hit;
                        o_cmd.live_we  = !r_hit;
                        o_cmd.live_val = 1'b1;
                    end
                    OP_FIND: begin
                        o_upd.hit_inc  = r_hit;
                        o_upd.miss_inc = !r_hit;
                    end
                    default: begin
                        o_wr_addr     = r_hit_a;
                        o_cmd.live_we = r_hit;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_oldest <= '0;
            r_used   <= '0;
            r_bytes  <= '0;
            r_ev     <= '0;
            r_chk_v  <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_op;
                        r_fk     <= i_fk;
                        r_lk     <= i_lk;
                        r_sz     <= i_vsize;
                        r_hd     <= i_vhandle;
                        r_ev     <= '0;
                        r_fh     <= '0;
                        r_fs     <= '0;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_tfk        <= r_fk;
                    r_tlk        <= r_lk;
                    r_evict_mode <= 1'b0;
                    r_scan       <= '0;
                    r_chk_v      <= 1'b0;
                    r_hit        <= 1'b0;
                    if (r_op == OP_INSERT) begin
                        if ({16'd0, r_sz} > i_byte_cap || lim == '0) begin
                            r_status <= ST_REJECT;
                            r_state  <= S_OUT;
                        end else begin
                            r_state  <= S_EVCHK;
                        end
                    end else if (r_op == OP_FIND || r_op == OP_ERASE) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_status <= ST_REJECT;
                        r_state  <= S_OUT;
                    end
                end
                S_EVCHK: begin
                    r_scan  <= '0;
                    r_chk_v <= 1'b0;
                    r_hit   <= 1'b0;
                    if (need_evict) begin
                        r_state <= S_EVRD;
                    end else begin
                        r_tfk        <= r_fk;
                        r_tlk        <= r_lk;
                        r_evict_mode <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_EVRD: r_state <= S_EVDAT;
                S_EVDAT: begin
                    r_tfk        <= i_rd_fk;
                    r_tlk        <= i_rd_lk;
                    r_evict_mode <= 1'b1;
                    r_bytes      <= (r_bytes >= 48'(i_rd_sz)) ? r_bytes - 48'(i_rd_sz) : '0;
                    r_state      <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_scan < (AW + 1)'(DEPTH)) begin
                        r_chk_v <= 1'b1;
                        r_chk_a <= r_scan[AW-1:0];
                        r_scan  <= r_scan + (AW + 1)'(1);
                    end else begin
                        r_chk_v <= 1'b0;
                    end
                    if (hit_now && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_a   <= r_chk_a;
                        r_hit_pay <= i_rd_pay;
                        r_hit_sz  <= i_rd_sz;
                    end
                    if (r_chk_v && r_chk_a == AW'(DEPTH - 1)) r_state <= S_SCEND;
                end
                S_SCEND: begin
                    r_chk_v <= 1'b0;
                    r_state <= r_evict_mode ? S_EVCLR : S_FIN;
                end
                S_EVCLR: begin
                    r_oldest <= (r_oldest == AW'(DEPTH - 1)) ? '0 : r_oldest + AW'(1);
                    r_used   <= r_used - UW'(1);
                    r_ev     <= r_ev + UW'(1);
                    r_state  <= S_EVCHK;
                end
                S_FIN: begin
                    case (r_op)
                        OP_INSERT: begin
                            if (r_hit) begin
                                r_status <= ST_LIVE;
                            end else begin
                                r_status <= ST_DONE;
                                r_used   <= r_used + UW'(1);
                                r_bytes  <= add_sum[48] ? MAX48 : add_sum[47:0];
                            end
                        end
                        OP_FIND: begin
                            r_status <= r_hit ? ST_DONE : ST_MISS;
                            if (r_hit) begin
                                r_fh <= r_hit_pay;
                                r_fs <= r_hit_sz;
                            end
                        end
                        default: r_status <= r_hit ? ST_DONE : ST_MISS;
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_status    = r_status;
    assign o_fh        = r_fh;
    assign o_fs        = r_fs;
    assign o_evicted   = r_ev;
    assign o_used      = r_used;
    assign o_bytes     = r_bytes;
    assign o_wr_fk     = r_fk;
    assign o_wr_lk     = r_lk;
    assign o_wr_sz     = r_sz;
    assign o_wr_pay    = r_hd;
endmodule
`default_nettype wire

@@ rtl/core/fifo_cache_with_byte_budget_top.sv @@
// ----------------------------------------------------------------------------
// FIFO cache with byte budget
// Key-value cache, FIFO replacement, entry limit and byte budget.
//
//   channel  dir  handshake               payload
//   in       in   i_in_valid/o_in_stall   op, keys, size, handle
//   out      out  o_out_valid/i_out_stall status, handle, size, counts
//   cfg      in   psel/penable/pwrite     paddr, pwdata, prdata
//
// Find and erase: one key scan. Insert: one key scan plus one scan per evicted
// entry; each scan reads one slot a cycle from the store.
// After reset a live-bit clearing pass runs over every slot before the first transfer.
// A result holds in the output register until the out stall drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fifo_cache_with_byte_budget_top_defines.svh"
module fifo_cache_with_byte_budget_top #(
    parameter int DEPTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_file_hash,
    input  wire logic [63:0] i_location_hash,
    input  wire logic [31:0] i_value_size,
    input  wire logic [31:0] i_value_handle,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [1:0]  o_status,
    output logic      [31:0] o_found_handle,
    output logic      [31:0] o_found_size,
    output logic      [10:0] o_evicted,
    output logic      [10:0] o_entry_count,
    output logic      [47:0] o_bytes_in_use,
    output logic      [47:0] o_hits,
    output logic      [47:0] o_misses
);
    import fcb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int UW = $clog2(DEPTH + 1);

    logic [10:0]   entry_cap;
    logic [47:0]   byte_cap;
    t_stat_upd     upd;
    t_mem_cmd      cmd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [63:0]   rd_fk, rd_lk, wr_fk, wr_lk;
    logic [31:0]   rd_sz, rd_pay, wr_sz, wr_pay;
    logic          rd_live;
    logic [UW-1:0] ev, used;
    logic          out_reject;
    logic          out_no_data;

    assign pready = 1'b1;

    fcb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .i_upd       (upd),
        .o_entry_cap (entry_cap),
        .o_byte_cap  (byte_cap),
        .o_hits      (o_hits),
        .o_misses    (o_misses)
    );

    fcb_store #(.DEPTH(DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_fk   (rd_fk),
        .o_rd_lk   (rd_lk),
        .o_rd_sz   (rd_sz),
        .o_rd_pay  (rd_pay),
        .o_rd_live (rd_live),
        .i_wr_addr (wr_addr),
        .i_cmd     (cmd),
        .i_wr_fk   (wr_fk),
        .i_wr_lk   (wr_lk),
        .i_wr_sz   (wr_sz),
        .i_wr_pay  (wr_pay)
    );

    fcb_seq #(.DEPTH(DEPTH)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_fk        (i_file_hash),
        .i_lk        (i_location_hash),
        .i_vsize     (i_value_size),
        .i_vhandle   (i_value_handle),
        .i_entry_cap (entry_cap),
        .i_byte_cap  (byte_cap),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_fh        (o_found_handle),
        .o_fs        (o_found_size),
        .o_evicted   (ev),
        .o_used      (used),
        .o_bytes     (o_bytes_in_use),
        .o_upd       (upd),
        .o_rd_addr   (rd_addr),
        .i_rd_fk     (rd_fk),
        .i_rd_lk     (rd_lk),
        .i_rd_sz     (rd_sz),
        .i_rd_pay    (rd_pay),
        .i_rd_live   (rd_live),
        .o_wr_addr   (wr_addr),
        .o_cmd       (cmd),
        .o_wr_fk     (wr_fk),
        .o_wr_lk     (wr_lk),
        .o_wr_sz     (wr_sz),
        .o_wr_pay    (wr_pay)
    );

    assign o_evicted     = 11'(ev);
    assign o_entry_count = 11'(used);

    assign out_reject  = o_out_valid && o_status == ST_REJECT;
    assign out_no_data = o_found_handle == 32'd0 && o_found_size == 32'd0;

    `FCB_ASSERT_SAME(a_busy_out, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `FCB_ASSERT_NEXT(a_busy_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `FCB_ASSERT_SAME(a_reject_no_evict, i_clk, i_rst_n, out_reject, o_evicted == 11'd0)
    `FCB_ASSERT_SAME(a_miss_no_data, i_clk, i_rst_n, o_out_valid && o_status != ST_DONE, out_no_data)
endmodule
`default_nettype wire

@@ verif/tb_fifo_cache_with_byte_budget_top.sv @@
// ----------------------------------------------------------------------------
// FIFO cache with byte budget testbench
// Drives insert/find/erase transfers with random gaps and output stalls,
// predicts every result with an in-bench cache model and compares all fields.
// Register writes happen between phases, the first ones while the post-reset clear runs.
// ----------------------------------------------------------------------------
module tb_fifo_cache_with_byte_budget_top;
    timeunit 1ns;
    timeprecision 1ps;
    import fcb_pkg::*;

    localparam int SLOTS = 1024;
    localparam int IDLE_LIMIT = 5_000_000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] handle;
        logic [31:0] size;
        logic [10:0] evicted;
        logic [10:0] count;
        logic [47:0] bytes;
        logic [47:0] hits;
        logic [47:0] misses;
    } t_cache_result;

    class fcb_scoreboard;
        logic [10:0] entry_cap = 11'd1024;
        logic [47:0] byte_cap = 48'd268435456;
        logic        stats_on = 1'b0;
        int unsigned head_slot = 0;
        int unsigned used = 0;
        logic [47:0] byte_sum = '0;
        logic [47:0] hit_cnt = '0;
        logic [47:0] miss_cnt = '0;
        logic [63:0] file_key [SLOTS];
        logic [63:0] loc_key  [SLOTS];
        logic [31:0] slot_size [SLOTS];
        logic [31:0] slot_handle [SLOTS];
        bit          live [SLOTS];
        t_cache_result pending [$];
        int          mismatches = 0;

        function void write_reg(logic [1:0] idx, logic [63:0] val);
            if (idx == REG_ENTRY_CAP) begin
                if (val[10:0] > entry_cap) entry_cap = val[10:0];
            end else if (idx == REG_BYTE_CAP) begin
                if (val[47:0] > byte_cap) byte_cap = val[47:0];
            end else if (idx == REG_STATS) begin
                stats_on = val[0];
                hit_cnt = '0;
                miss_cnt = '0;
            end
        endfunction

        function int find_slot(logic [63:0] fk, logic [63:0] lk);
            for (int i = 0; i < SLOTS; i++)
                if (live[i] && file_key[i] == fk && loc_key[i] == lk) return i;
            return -1;
        endfunction

        function void drop_oldest();
            int unsigned s;
            s = head_slot;
            byte_sum = (byte_sum >= slot_size[s]) ? byte_sum - slot_size[s] : '0;
            for (int i = 0; i < SLOTS; i++)
                if (live[i] && file_key[i] == file_key[s] && loc_key[i] == loc_key[s])
                    live[i] = 0;
            live[s] = 0;
            head_slot = (s + 1) % SLOTS;
            used--;
        endfunction

        function void note_transfer(logic [1:0] op, logic [63:0] fk, logic [63:0] lk,
                                    logic [31:0] sz, logic [31:0] hd);
            t_cache_result r;
            int unsigned lim, s;
            int hit;
            logic [48:0] sum;
            r = '{status: ST_DONE, handle: '0, size: '0, evicted: '0, count: '0,
                  bytes: '0, hits: '0, misses: '0};
            lim = (entry_cap > SLOTS) ? SLOTS : entry_cap;
            if (op == OP_INSERT) begin
                if ({16'd0, sz} > byte_cap || lim < 1) begin
                    r.status = ST_REJECT;
                end else begin
                    while (used > 0 && (used >= lim || byte_sum >= byte_cap)) begin
                        drop_oldest();
                        r.evicted++;
                    end
                    if (find_slot(fk, lk) >= 0) begin
                        r.status = ST_LIVE;
                    end else begin
                        s = (head_slot + used) % SLOTS;
                        file_key[s] = fk;
                        loc_key[s] = lk;
                        slot_size[s] = sz;
                        slot_handle[s] = hd;
                        live[s] = 1;
                        used++;
                        sum = byte_sum + sz;
                        byte_sum = sum[48] ? MAX48 : sum[47:0];
                    end
                end
            end else if (op == OP_FIND) begin
                hit = find_slot(fk, lk);
                if (hit >= 0) begin
                    r.handle = slot_handle[hit];
                    r.size = slot_size[hit];
                    if (stats_on && hit_cnt != MAX48) hit_cnt++;
                end else begin
                    r.status = ST_MISS;
                    if (stats_on && miss_cnt != MAX48) miss_cnt++;
                end
            end else if (op == OP_ERASE) begin
                hit = find_slot(fk, lk);
                if (hit >= 0) live[hit] = 0;
                else r.status = ST_MISS;
            end else begin
                r.status = ST_REJECT;
            end
            r.count = used[10:0];
            r.bytes = byte_sum;
            r.hits = hit_cnt;
            r.misses = miss_cnt;
            pending = {pending, r};
        endfunction

        function void check_result(t_cache_result got);
            t_cache_result exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
                return;
            end
            exp = pending.pop_front();
            if (got != exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st=%0d h=%h s=%h ev=%0d n=%0d b=%0d ",
                        exp.status, exp.handle, exp.size, exp.evicted, exp.count,
                        exp.bytes,
                        "hit=%0d mis=%0d / got st=%0d h=%h s=%h ev=%0d n=%0d ",
                        exp.hits, exp.misses,
                        got.status, got.handle, got.size, got.evicted, got.count,
                        "b=%0d hit=%0d mis=%0d",
                        got.bytes, got.hits, got.misses);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        i_in_valid, o_in_stall;
    logic [1:0]  i_op;
    logic [63:0] i_file_hash, i_location_hash;
    logic [31:0] i_value_size, i_value_handle;
    logic        o_out_valid, i_out_stall;
    logic [1:0]  o_status;
    logic [31:0] o_found_handle, o_found_size;
    logic [10:0] o_evicted, o_entry_count;
    logic [47:0] o_bytes_in_use, o_hits, o_misses;

    fifo_cache_with_byte_budget_top u_top (.*);

    fcb_scoreboard cache_sb = new();
    logic [63:0] file_pool [6];
    logic [63:0] loc_pool [6];
    int   stall_pct = 30;
    bit   hold_off = 0;
    int   idle_cycles = 0;
    int   sizing = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        t_cache_result got;
        int hold_cnt;
        if (o_out_valid && !i_out_stall) begin
            got = '{status: o_status, handle: o_found_handle, size: o_found_size,
                    evicted: o_evicted, count: o_entry_count, bytes: o_bytes_in_use,
                    hits: o_hits, misses: o_misses};
            cache_sb.check_result(got);
        end
        if (hold_off) begin
            i_out_stall <= 1'b1;
            hold_cnt++;
            if (hold_cnt >= 3000) hold_off = 0;
        end else begin
            hold_cnt = 0;
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        cache_sb.write_reg(idx, val);
    endtask

    task automatic send(logic [1:0] op, logic [63:0] fk, logic [63:0] lk,
                        logic [31:0] sz, logic [31:0] hd);
        i_in_valid <= 1'b1;
        i_op <= op;
        i_file_hash <= fk;
        i_location_hash <= lk;
        i_value_size <= sz;
        i_value_handle <= hd;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        cache_sb.note_transfer(op, fk, lk, sz, hd);
    endtask

    task automatic gap();
        if ($urandom_range(3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (cache_sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_size();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sizing == 2) return $urandom;
        if (sel < 60) return $urandom_range(32'h0800_0000 << sizing, 32'h0080_0000);
        if (sel < 75) return $urandom_range(32'hFFFF_FFFF, 32'h1000_0001);
        if (sel < 85) return '0;
        return $urandom_range(32'hFFFF);
    endfunction

    task automatic random_items(int n);
        logic [1:0]  op;
        logic [63:0] fk, lk;
        int unsigned sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            op = (sel < 50) ? OP_INSERT : (sel < 80) ? OP_FIND :
                 (sel < 95) ? OP_ERASE : OP_UNUSED;
            fk = ($urandom_range(9) == 0) ? {$urandom, $urandom} : file_pool[$urandom_range(5)];
            lk = ($urandom_range(9) == 0) ? {$urandom, $urandom} : loc_pool[$urandom_range(5)];
            send(op, fk, lk, pick_size(), $urandom);
            if (k == n / 2 && sizing == 0) hold_off = 1;
            gap();
        end
    endtask

    initial begin
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_in_valid = 0; i_op = OP_INSERT; i_file_hash = '0; i_location_hash = '0;
        i_value_size = '0; i_value_handle = '0; i_out_stall = 0;
        file_pool[0] = '0;
        file_pool[1] = '1;
        loc_pool[0] = '0;
        loc_pool[1] = '1;
        for (int i = 2; i < 6; i++) begin
            file_pool[i] = {$urandom, $urandom};
            loc_pool[i] = {$urandom, $urandom};
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        reg_write(REG_ENTRY_CAP, 64'd0);
        reg_write(REG_BYTE_CAP, 64'd0);

        // directed
        send(OP_INSERT, '0, '0, '0, '0);
        send(OP_INSERT, '0, '0, 32'd5, 32'd1);
        send(OP_FIND, '0, '0, '0, '0);
        send(OP_FIND, '1, '0, '0, '0);
        send(OP_ERASE, '0, '0, '0, '0);
        send(OP_ERASE, '0, '0, '0, '0);
        send(OP_INSERT, '0, '0, 32'd7, 32'hAAAA_5555);
        send(OP_INSERT, '1, '1, 32'h1000_0001, '1);
        send(OP_INSERT, '1, '1, '1, '1);
        send(OP_INSERT, '1, '1, 32'h1000_0000, '1);
        send(OP_INSERT, '0, '1, 32'd3, 32'h5555_AAAA);
        send(OP_FIND, '0, '0, '0, '0);
        send(OP_FIND, '1, '1, '0, '0);
        send(OP_UNUSED, '1, '1, '1, '1);
        send(OP_INSERT, '0, '0, 32'h0FFF_FFFF, 32'd9);
        send(OP_FIND, '0, '1, '0, '0);
        drain();

        reg_write(REG_STATS, 64'd1);
        stall_pct = 40;
        random_items(250);
        drain();

        reg_write(REG_BYTE_CAP, 64'h4000_0000);
        reg_write(REG_ENTRY_CAP, 64'h7FF);
        sizing = 1;
        stall_pct = 0;
        random_items(180);
        drain();

        reg_write(REG_STATS, 64'd0);
        reg_write(REG_BYTE_CAP, 64'hFFFF_FFFF_FFFF);
        sizing = 2;
        stall_pct = 60;
        random_items(150);
        drain();

        if (cache_sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/fcb_pkg.sv
rtl/core/fcb_regs.sv
rtl/core/fcb_store.sv
rtl/core/fcb_seq.sv
rtl/core/fifo_cache_with_byte_budget_top.sv
verif/tb_fifo_cache_with_byte_budget_top.sv
